@@ design/qso_pkg.sv @@
// shared types for the quadrature sine oscillator: controller states,
// datapath command and status structs, register index codes
// no dependencies
`default_nettype none

package qso_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_STEP_COSINE = 2'd0,
    REG_STEP_SINE   = 2'd1,
    REG_AMPLITUDE   = 2'd2,
    REG_DC_OFFSET   = 2'd3
  } reg_idx_t;

  // operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MUL_PR_SC,
    MUL_PI_SS,
    MUL_PR_SS,
    MUL_PI_SC,
    MUL_NR_NR,
    MUL_NI_NI,
    MUL_AMP_PR,
    MUL_AMP_PI
  } mul_sel_t;

  // what happens to the floored product of the last multiply step
  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_NR,
    ACC_NI,
    ACC_NORM,
    ACC_COS,
    ACC_OUT
  } acc_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6,
    ST_NORM,
    ST_DIV,
    ST_UPD,
    ST_O1,
    ST_O2,
    ST_O3
  } state_t;

  typedef struct packed {
    logic     start;
    mul_sel_t mul_sel;
    logic     prod_en;
    acc_op_t  acc_op;
    logic     div_step;
    logic     phase_upd;
  } dp_cmd_t;

  typedef struct packed {
    logic norm_zero;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ design/qso_ctrl.sv @@
// sequencer for the oscillator: walks the multiply steps, runs the divider
// unless the squared magnitude is zero and hands the result to the output register
// depends on qso_pkg
`default_nettype none

module qso_ctrl import qso_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 30
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  localparam int QW = DATA_WIDTH + FRAC_BITS;
  localparam int CW = $clog2(QW);

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    in_ready      = 1'b0;
    cmd.start     = 1'b0;
    cmd.mul_sel   = MUL_PR_SC;
    cmd.prod_en   = 1'b0;
    cmd.acc_op    = ACC_NONE;
    cmd.div_step  = 1'b0;
    cmd.phase_upd = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // no request is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.start  = 1'b1;
          state_next = ST_M1;
        end
      end
      ST_M1: begin
        cmd.mul_sel = MUL_PR_SC;
        cmd.prod_en = 1'b1;
        state_next  = ST_M2;
      end
      ST_M2: begin
        cmd.mul_sel = MUL_PI_SS;
        cmd.prod_en = 1'b1;
        cmd.acc_op  = ACC_LOAD;
        state_next  = ST_M3;
      end
      ST_M3: begin
        cmd.mul_sel = MUL_PR_SS;
        cmd.prod_en = 1'b1;
        cmd.acc_op  = ACC_NR;
        state_next  = ST_M4;
      end
      ST_M4: begin
        cmd.mul_sel = MUL_PI_SC;
        cmd.prod_en = 1'b1;
        cmd.acc_op  = ACC_LOAD;
        state_next  = ST_M5;
      end
      ST_M5: begin
        cmd.mul_sel = MUL_NR_NR;
        cmd.prod_en = 1'b1;
        cmd.acc_op  = ACC_NI;
        state_next  = ST_M6;
      end
      ST_M6: begin
        cmd.mul_sel = MUL_NI_NI;
        cmd.prod_en = 1'b1;
        cmd.acc_op  = ACC_LOAD;
        state_next  = ST_NORM;
      end
      ST_NORM: begin
        cmd.acc_op = ACC_NORM;
        count_next = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (stat.norm_zero) begin
          state_next = ST_UPD;
        end else begin
          cmd.div_step = 1'b1;
          count_next   = count + 1'b1;
          if (count == CW'(QW - 1)) begin
            state_next = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        cmd.phase_upd = 1'b1;
        state_next    = ST_O1;
      end
      ST_O1: begin
        cmd.mul_sel = MUL_AMP_PR;
        cmd.prod_en = 1'b1;
        state_next  = ST_O2;
      end
      ST_O2: begin
        cmd.mul_sel = MUL_AMP_PI;
        cmd.prod_en = 1'b1;
        cmd.acc_op  = ACC_COS;
        state_next  = ST_O3;
      end
      ST_O3: begin
        // hold the finished sine product until the output slot frees up
        if (stat.out_free) begin
          cmd.acc_op = ACC_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ design/qso_dp.sv @@
// datapath of the oscillator: configuration registers, phasor, one shared
// multiplier, accumulator, two restoring divider lanes and the output register
// depends on qso_pkg
`default_nettype none

module qso_dp import qso_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 30
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire dp_cmd_t                      cmd,
  output dp_stat_t                          stat,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [DATA_WIDTH-1:0]        cfg_data,
  input  wire logic                         restart,
  input  wire logic                         block_end,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0]      cosine_out,
  output logic signed [DATA_WIDTH-1:0]      sine_out,
  output logic                              block_end_out
);

  localparam int DW = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int SW = 2 * DW - F + 2;   // floored products and their sums
  localparam int NW = 2 * DW - F;       // squared magnitude, unsigned
  localparam int QW = DW + F;           // dividend and quotient

  localparam logic [DW-1:0] ONE_Q = {{(DW-1){1'b0}}, 1'b1} << F;
  localparam logic signed [SW-1:0] SAT_HI_S = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO_S = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] MAX_DW = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MIN_DW = {1'b1, {(DW-1){1'b0}}};
  localparam logic [QW-1:0] Q_POS_LIM = {{(F+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic [QW-1:0] Q_NEG_LIM = {{F{1'b0}}, 1'b1, {(DW-1){1'b0}}};

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] v);
    if (v > SAT_HI_S) return MAX_DW;
    if (v < SAT_LO_S) return MIN_DW;
    return v[DW-1:0];
  endfunction

  logic signed [DW-1:0]   step_cosine, step_sine, amplitude, dc_offset;
  logic signed [DW-1:0]   phase_real, phase_imag;
  logic signed [DW-1:0]   nr, ni, cos_hold;
  logic                   be_hold;
  logic signed [DW-1:0]   mul_a, mul_b;
  logic signed [2*DW-1:0] prod, prod_shift;
  logic signed [SW-1:0]   prod_fl, acc, acc_sub, acc_add, off_sum;
  logic signed [SW-1:0]   dc_ext;
  logic [NW-1:0]          norm;

  logic [QW-1:0]          dq    [2];
  logic [NW-1:0]          rem   [2];
  logic                   neg   [2];
  logic signed [DW-1:0]   q_sat [2];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cosine <= ONE_Q;
      step_sine   <= '0;
      amplitude   <= ONE_Q;
      dc_offset   <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_STEP_COSINE: step_cosine <= cfg_data;
        REG_STEP_SINE:   step_sine   <= cfg_data;
        REG_AMPLITUDE:   amplitude   <= cfg_data;
        REG_DC_OFFSET:   dc_offset   <= cfg_data;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MUL_PR_SC:  begin mul_a = phase_real; mul_b = step_cosine; end
      MUL_PI_SS:  begin mul_a = phase_imag; mul_b = step_sine;   end
      MUL_PR_SS:  begin mul_a = phase_real; mul_b = step_sine;   end
      MUL_PI_SC:  begin mul_a = phase_imag; mul_b = step_cosine; end
      MUL_NR_NR:  begin mul_a = nr;         mul_b = nr;          end
      MUL_NI_NI:  begin mul_a = ni;         mul_b = ni;          end
      MUL_AMP_PR: begin mul_a = amplitude;  mul_b = phase_real;  end
      MUL_AMP_PI: begin mul_a = amplitude;  mul_b = phase_imag;  end
      default:    begin mul_a = phase_real; mul_b = step_cosine; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.prod_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // floor to the fraction point, then add or subtract
  assign prod_shift = prod >>> F;
  assign prod_fl    = prod_shift[SW-1:0];
  assign acc_sub    = acc - prod_fl;
  assign acc_add    = acc + prod_fl;
  assign dc_ext     = {{(SW-DW){dc_offset[DW-1]}}, dc_offset};
  assign off_sum    = prod_fl + dc_ext;

  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      ACC_LOAD: acc <= prod_fl;
      ACC_NR:   nr <= sat_dw(acc_sub);
      ACC_NI:   ni <= sat_dw(acc_add);
      ACC_NORM: norm <= acc_add[NW-1:0];
      ACC_COS:  cos_hold <= sat_dw(off_sum);
      default: ;
    endcase
  end

  // restoring divider lanes: lane 0 real part, lane 1 imaginary part
  for (genvar g = 0; g < 2; g++) begin : g_lane
    logic signed [DW-1:0] lane_in;
    logic [DW-1:0]        lane_mag;
    logic [NW:0]          trial, diff;
    logic                 fits;

    assign lane_in  = (g == 0) ? nr : ni;
    assign lane_mag = lane_in[DW-1] ? DW'(-lane_in) : lane_in;
    assign trial    = {rem[g], dq[g][QW-1]};
    assign diff     = trial - {1'b0, norm};
    assign fits     = trial >= {1'b0, norm};

    always_ff @(posedge clk) begin
      if (cmd.acc_op == ACC_NORM) begin
        rem[g] <= '0;
        dq[g]  <= {lane_mag, {F{1'b0}}};
        neg[g] <= lane_in[DW-1];
      end else if (cmd.div_step) begin
        rem[g] <= fits ? diff[NW-1:0] : trial[NW-1:0];
        dq[g]  <= {dq[g][QW-2:0], fits};
      end
    end

    // signed quotient, truncated toward zero and saturated
    always_comb begin
      if (!neg[g]) begin
        q_sat[g] = (dq[g] > Q_POS_LIM) ? MAX_DW : dq[g][DW-1:0];
      end else begin
        q_sat[g] = (dq[g] > Q_NEG_LIM) ? MIN_DW : DW'(-dq[g][DW-1:0]);
      end
    end
  end

  // phasor
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_real <= ONE_Q;
      phase_imag <= '0;
    end else if (cmd.start && restart) begin
      phase_real <= ONE_Q;
      phase_imag <= '0;
    end else if (cmd.phase_upd) begin
      if (norm == '0) begin
        phase_real <= nr;
        phase_imag <= ni;
      end else begin
        phase_real <= q_sat[0];
        phase_imag <= q_sat[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      be_hold <= block_end;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.acc_op == ACC_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_op == ACC_OUT) begin
      cosine_out    <= cos_hold;
      sine_out      <= sat_dw(off_sum);
      block_end_out <= be_hold;
    end
  end

  assign stat.norm_zero = (norm == '0);
  assign stat.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

@@ design/quadrature_sine_oscillator.sv @@
// top level of the quadrature sine oscillator: sequencer plus datapath
// depends on qso_pkg, qso_ctrl, qso_dp
//
// channel   dir  handshake             payload
// input     in   in_valid / in_ready   restart, block_end
// output    out  out_valid / out_ready cosine_out, sine_out, block_end_out
// config    in   cfg_we                cfg_index, cfg_data
//
// one request goes through the multiply steps, the restoring divider that
// retires one quotient bit per cycle and the output steps before the next
// acceptance; with a zero squared magnitude the divide is skipped
// the rotation and output scaling share one registered multiplier
// reset restores the step, gain and offset registers and sets the phasor to (1, 0)
// a stalled output holds the finished request in the last step; a new request
// is taken as soon as the result moves into the output register
`default_nettype none

module quadrature_sine_oscillator import qso_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 30
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // configuration write port
  input  wire logic                    cfg_we,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [DATA_WIDTH-1:0]   cfg_data,
  // tick requests
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    restart,
  input  wire logic                    block_end,
  // oscillator samples
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [DATA_WIDTH-1:0] cosine_out,
  output logic signed [DATA_WIDTH-1:0] sine_out,
  output logic                         block_end_out
);

  // command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: multiply steps, divide count, output hand-off
  qso_ctrl #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // datapath: rotate, normalize by squared magnitude, scale and offset
  qso_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .restart       (restart),
    .block_end     (block_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cosine_out    (cosine_out),
    .sine_out      (sine_out),
    .block_end_out (block_end_out)
  );

endmodule

`default_nettype wire

@@ test/tb.sv @@
// testbench for quadrature_sine_oscillator: a table of directed tick requests, then
// random phases of settings, checked against a phasor predictor kept in this file
// depends on qso_pkg and the design sources
module tb;
  import qso_pkg::*;

  localparam int DW = 32;
  localparam int FB = 30;

  // common Q2.30 values
  localparam logic [31:0] Q_ONE     = 32'h4000_0000;
  localparam logic [31:0] Q_NEG_ONE = 32'hC000_0000;
  localparam logic [31:0] Q_R45     = 32'h2D41_3CCD;   // cos and sin of 45 degrees
  localparam logic [31:0] S_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] S_MIN     = 32'h8000_0000;
  localparam logic [31:0] OFS_A     = 32'h1234_5678;

  localparam longint ONE_L  = 64'sd1 << FB;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  localparam int DIR_ROWS   = 25;
  localparam int RND_PHASES = 8;
  localparam int PHASE_LEN  = 78;
  localparam int HOLD_AT    = DIR_ROWS + 30;   // result count at which the sink holds off
  localparam int HOLD_LEN   = 400;
  localparam int SETTLE     = 100;             // longer than one request period
  localparam int LIMIT      = 400_000;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [1:0]           cfg_index = REG_STEP_COSINE;
  logic [DW-1:0]        cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 restart   = 1'b0;
  logic                 block_end = 1'b0;
  logic                 out_ready = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic signed [DW-1:0] cosine_out;
  logic signed [DW-1:0] sine_out;
  logic                 block_end_out;

  quadrature_sine_oscillator #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .restart      (restart),
    .block_end    (block_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cosine_out   (cosine_out),
    .sine_out     (sine_out),
    .block_end_out(block_end_out)
  );

  // 12-unit clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // one expected oscillator sample
  typedef struct packed {
    logic [31:0] cos_v;
    logic [31:0] sin_v;
    logic        blk_end;
  } osc_sample_t;

  // one row of the directed table; wr loads all four registers first,
  // typed rows carry their expected sample, others use the predictor
  typedef struct packed {
    logic        wr;
    logic [31:0] c;
    logic [31:0] s;
    logic [31:0] a;
    logic [31:0] o;
    logic        rs;
    logic        be;
    logic        typed;
    logic [31:0] ec;
    logic [31:0] es;
  } tick_row_t;

  tick_row_t directed [DIR_ROWS] = '{
    // reset settings: unit step, unit gain, no offset
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1, Q_ONE, 32'h0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 1'b1, Q_ONE, 32'h0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1, 1'b1, Q_ONE, 32'h0},
    // quarter turn per tick
    '{1'b1, 32'h0, Q_ONE, Q_ONE, 32'h0, 1'b1, 1'b0, 1'b1, 32'h0, Q_ONE},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1, Q_NEG_ONE, 32'h0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 1'b1, 32'h0, Q_NEG_ONE},
    // step extremes: half turn, three-quarter turn
    '{1'b1, Q_NEG_ONE, 32'h0, Q_ONE, 32'h0, 1'b1, 1'b0, 1'b1, Q_NEG_ONE, 32'h0},
    '{1'b1, 32'h0, Q_NEG_ONE, Q_ONE, 32'h0, 1'b1, 1'b0, 1'b1, 32'h0, Q_NEG_ONE},
    // zero step: squared magnitude is zero, phasor stays at zero
    '{1'b1, 32'h0, 32'h0, Q_ONE, OFS_A, 1'b1, 1'b0, 1'b1, OFS_A, OFS_A},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 1'b1, OFS_A, OFS_A},
    // gain and offset extremes, output saturation
    '{1'b1, Q_ONE, 32'h0, S_MAX, S_MAX, 1'b1, 1'b0, 1'b1, S_MAX, S_MAX},
    '{1'b1, Q_ONE, 32'h0, S_MIN, S_MIN, 1'b1, 1'b1, 1'b1, S_MIN, S_MIN},
    '{1'b1, Q_ONE, 32'h0, S_MIN, 32'h0, 1'b1, 1'b0, 1'b1, S_MIN, 32'h0},
    '{1'b1, Q_ONE, 32'h0, S_MAX, S_MIN, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF, S_MIN},
    // 45 degree step
    '{1'b1, Q_R45, Q_R45, Q_ONE, 32'h0, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 1'b0, 32'h0, 32'h0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0},
    // magnitude above one, squared magnitude of two
    '{1'b1, Q_ONE, Q_ONE, Q_ONE, 32'h0, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 1'b0, 32'h0, 32'h0},
    // tiny step: the divide saturates the phasor
    '{1'b1, 32'h8000, 32'h0, Q_ONE, 32'h0, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
    '{1'b1, 32'h8000, 32'h8000, Q_ONE, 32'h0, 1'b1, 1'b1, 1'b0, 32'h0, 32'h0},
    // rotated phasor nonzero but its squared magnitude floors to zero
    '{1'b1, 32'h1, 32'h0, Q_ONE, 32'h0, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0},
    '{1'b1, Q_NEG_ONE, Q_NEG_ONE, S_MAX, Q_ONE, 1'b1, 1'b1, 1'b0, 32'h0, 32'h0}
  };

  // predictor copy of the registers and the phasor, reset values
  longint step_c = ONE_L;
  longint step_s = 0;
  longint gain   = ONE_L;
  longint offset = 0;
  longint osc_re = ONE_L;
  longint osc_im = 0;

  osc_sample_t expected_samples [$];
  int          mismatch_cnt = 0;
  int          cycle_cnt    = 0;
  bit          tx_burst     = 1'b0;   // sender sends back to back

  function automatic longint clamp32(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // rotate the phasor, divide by its squared magnitude, scale and offset for the output
  function automatic osc_sample_t advance_oscillator(input logic rs, input logic be);
    longint      nr;
    longint      ni;
    longint      mag2;
    osc_sample_t smp;
    if (rs) begin
      osc_re = ONE_L;
      osc_im = 0;
    end
    nr = clamp32(((osc_re * step_c) >>> FB) - ((osc_im * step_s) >>> FB));
    ni = clamp32(((osc_re * step_s) >>> FB) + ((osc_im * step_c) >>> FB));
    mag2 = ((nr * nr) >>> FB) + ((ni * ni) >>> FB);
    if (mag2 > 0) begin
      osc_re = clamp32((nr * ONE_L) / mag2);
      osc_im = clamp32((ni * ONE_L) / mag2);
    end else begin
      // zero magnitude: keep the rotated parts undivided
      osc_re = nr;
      osc_im = ni;
    end
    smp.cos_v   = 32'(clamp32(((gain * osc_re) >>> FB) + offset));
    smp.sin_v   = 32'(clamp32(((gain * osc_im) >>> FB) + offset));
    smp.blk_end = be;
    return smp;
  endfunction

  // drop valid and wait until every expected sample has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all four registers while the block is idle
  task automatic load_settings(input logic [31:0] c, s, a, o);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_STEP_COSINE;
    cfg_data  <= c;
    @(posedge clk);
    cfg_index <= REG_STEP_SINE;
    cfg_data  <= s;
    @(posedge clk);
    cfg_index <= REG_AMPLITUDE;
    cfg_data  <= a;
    @(posedge clk);
    cfg_index <= REG_DC_OFFSET;
    cfg_data  <= o;
    @(posedge clk);
    cfg_we <= 1'b0;
    step_c = longint'($signed(c));
    step_s = longint'($signed(s));
    gain   = longint'($signed(a));
    offset = longint'($signed(o));
  endtask

  // offer one tick request; valid stays high across back-to-back requests
  task automatic offer_tick(input logic rs, be, input logic typed,
                            input logic [31:0] ec, es);
    int          gap;
    osc_sample_t want;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    restart   <= rs;
    block_end <= be;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    want = advance_oscillator(rs, be);
    if (typed) begin
      want.cos_v = ec;
      want.sin_v = es;
    end
    expected_samples.push_back(want);
  endtask

  // stimulus: directed table, then random phases
  initial begin : stimulus
    logic [31:0] c;
    logic [31:0] s;
    logic [31:0] a;
    logic [31:0] o;
    logic [31:0] step_edges [3];
    real         th;
    step_edges = '{Q_NEG_ONE, 32'h0, Q_ONE};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].wr)
        load_settings(directed[i].c, directed[i].s, directed[i].a, directed[i].o);
      tx_burst = (i >= 14);
      offer_tick(directed[i].rs, directed[i].be, directed[i].typed,
                 directed[i].ec, directed[i].es);
    end

    for (int ph = 0; ph < RND_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: begin
          // step extremes
          c = step_edges[$urandom_range(0, 2)];
          s = step_edges[$urandom_range(0, 2)];
        end
        1: begin
          // anywhere between minus one and plus one
          c = $urandom_range(32'h8000_0000, 0) - Q_ONE;
          s = $urandom_range(32'h8000_0000, 0) - Q_ONE;
        end
        2: begin
          // tiny steps, divide saturation and zero magnitude
          c = $urandom_range(32'h0002_0000, 0) - 32'h0001_0000;
          s = $urandom_range(32'h0002_0000, 0) - 32'h0001_0000;
        end
        default: begin
          // unit-magnitude step, a plain sine oscillator
          th = $urandom_range(62831, 0) / 10000.0;
          c = $rtoi($cos(th) * 1073741824.0);
          s = $rtoi($sin(th) * 1073741824.0);
        end
      endcase
      case ($urandom_range(0, 3))
        0:       a = Q_ONE;
        1:       a = S_MAX;
        2:       a = S_MIN;
        default: a = $urandom();
      endcase
      case ($urandom_range(0, 3))
        0:       o = 32'h0;
        1:       o = $urandom();
        2:       o = $urandom_range(1, 0) ? S_MAX : S_MIN;
        default: o = $urandom_range(32'h0010_0000, 0) - 32'h0008_0000;
      endcase
      load_settings(c, s, a, o);
      tx_burst = ph[0];
      for (int k = 0; k < PHASE_LEN; k++)
        offer_tick($urandom_range(15, 0) == 0, $urandom_range(7, 0) == 0,
                   1'b0, 32'h0, 32'h0);
    end

    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  // sample sink: random stalls, fast stretches, and one long hold-off
  initial begin : sample_sink
    int          gap;
    int          taken;
    osc_sample_t want;
    taken = 0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      // the long hold-off lets the block fill up and stall its input
      if (taken == HOLD_AT)
        gap = HOLD_LEN;
      else if ((taken / 40) % 2 == 1)
        gap = 0;
      else
        gap = $urandom_range(0, 7);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      taken++;
      if (expected_samples.size() == 0) begin
        $error("sample with no request pending: cos %h sin %h", cosine_out, sine_out);
        mismatch_cnt++;
      end else begin
        want = expected_samples.pop_front();
        if (cosine_out !== want.cos_v) begin
          $error("cosine_out: expected %h, actual %h", want.cos_v, cosine_out);
          mismatch_cnt++;
        end
        if (sine_out !== want.sin_v) begin
          $error("sine_out: expected %h, actual %h", want.sin_v, sine_out);
          mismatch_cnt++;
        end
        if (block_end_out !== want.blk_end) begin
          $error("block_end_out: expected %b, actual %b", want.blk_end, block_end_out);
          mismatch_cnt++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

endmodule
